// ===== rtl/tdpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trial division prime test package
// Shared widths and reset values for the prime test core.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  localparam int CAND_W          = 24;
  localparam int LIMIT_W         = 20;
  localparam int VALUE_WIDTH_DEF = 24;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd100000;

endpackage

`default_nettype wire

// ===== rtl/tdpt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trial division prime test channels
// Valid/ready channels for candidate words and result words.
// ----------------------------------------------------------------------------
interface tdpt_in_if;
  import tdpt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CAND_W-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_out_if;
  import tdpt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CAND_W-1:0] tested_value;
  logic              prime_flag;
  logic              limit_reached;

  modport source (output valid, output tested_value, output prime_flag,
                  output limit_reached, input ready);
  modport sink   (input valid, input tested_value, input prime_flag,
                  input limit_reached, output ready);
endinterface

`default_nettype wire

// ===== rtl/tdpt_rem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trial division remainder unit
// Restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tdpt_rem #(
  parameter int VW = 24,
  parameter int DW = 14
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [VW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      rem
);
  import tdpt_pkg::*;

  localparam int CW = $clog2(VW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0] shf_r, shf_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW:0]   trial;

  assign trial = {rem_r, shf_r[VW-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    shf_nxt  = shf_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(VW);
      shf_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      shf_nxt = {shf_r[VW-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = DW'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = DW'(trial);
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    shf_r <= shf_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ===== rtl/trial_division_prime_test_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trial division prime test core
// Tests one candidate word at a time for primality and counts words.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    candidate
// out_ch    out  valid/ready    tested_value, prime_flag, limit_reached
// cfg       in   write enable   item_limit
//
// Each word is divided by trial divisors counting up from 2 while the divisor
// squared does not exceed the word; each divisor costs one pass through the
// bit-serial remainder unit. Worst case for 24 bits is about 4096 divisors.
// Reset is synchronous and active low, clears the count and restores the
// default limit.
// A new word is taken as soon as the core is idle, even while a result stalls.
// ----------------------------------------------------------------------------
module trial_division_prime_test_core #(
  parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  tdpt_in_if.sink                           in_ch,
  tdpt_out_if.source                        out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [tdpt_pkg::LIMIT_W-1:0] cfg_wdata
);
  import tdpt_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int DW = VW / 2 + 2;
  localparam int SW = VW + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_START,
    ST_DIV,
    ST_FINISH
  } state_t;

  state_t             state_r, state_nxt;
  logic [VW-1:0]      n_r, n_nxt;
  logic [DW-1:0]      d_r, d_nxt;
  logic [SW-1:0]      sq_r, sq_nxt;
  logic               prime_r, prime_nxt;
  logic               hit_r, hit_nxt;
  logic [LIMIT_W-1:0] count_r, count_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CAND_W-1:0]  out_value_r, out_value_nxt;
  logic               out_prime_r, out_prime_nxt;
  logic               out_hit_r, out_hit_nxt;

  logic               div_start;
  logic               div_done;
  logic [DW-1:0]      div_rem;
  logic [VW-1:0]      cand_n;
  logic [LIMIT_W-1:0] count_inc;

  tdpt_rem #(
    .VW (VW),
    .DW (DW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (n_r),
    .divisor  (d_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign cand_n    = VW'(in_ch.candidate);
  assign count_inc = (count_r < limit_r) ? count_r + LIMIT_W'(1) : count_r;
  assign div_start = (state_r == ST_START);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    prime_nxt     = prime_r;
    hit_nxt       = hit_r;
    count_nxt     = count_r;
    limit_nxt     = cfg_we ? cfg_wdata : limit_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    out_value_nxt = out_value_r;
    out_prime_nxt = out_prime_r;
    out_hit_nxt   = out_hit_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          n_nxt     = cand_n;
          d_nxt     = DW'(2);
          sq_nxt    = SW'(4);
          count_nxt = count_inc;
          hit_nxt   = (count_inc >= limit_r);
          if (cand_n < VW'(2)) begin
            prime_nxt = 1'b0;
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (SW'(n_r) < sq_r) begin
          prime_nxt = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_rem == '0) begin
            prime_nxt = 1'b0;
            state_nxt = ST_FINISH;
          end else begin
            d_nxt     = d_r + DW'(1);
            sq_nxt    = sq_r + SW'({d_r, 1'b0}) + SW'(1);
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = CAND_W'(n_r);
          out_prime_nxt = prime_r;
          out_hit_nxt   = hit_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    prime_r     <= prime_nxt;
    hit_r       <= hit_nxt;
    out_value_r <= out_value_nxt;
    out_prime_r <= out_prime_nxt;
    out_hit_r   <= out_hit_nxt;
  end

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.tested_value  = out_value_r;
  assign out_ch.prime_flag    = out_prime_r;
  assign out_ch.limit_reached = out_hit_r;

endmodule

`default_nettype wire

// ===== rtl/tdpt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trial division prime test checker
// Port-level checks on the prime test core, attached by bind.
// ----------------------------------------------------------------------------
module tdpt_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [tdpt_pkg::CAND_W-1:0] out_tested_value,
  input wire logic                        out_prime_flag
);
  import tdpt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_tested_value) && $stable(out_prime_flag))
    else $error("result word changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("core ready right after taking a word");

  a_small_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_tested_value == '0 || out_tested_value == CAND_W'(1))
      |-> !out_prime_flag)
    else $error("zero or one flagged prime");

  a_even_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tested_value[0] && out_tested_value > CAND_W'(2)
      |-> !out_prime_flag)
    else $error("even number above two flagged prime");

endmodule

bind trial_division_prime_test_core tdpt_checker u_tdpt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_tested_value (out_ch.tested_value),
  .out_prime_flag   (out_ch.prime_flag)
);

`default_nettype wire
